### design/zfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zonal flocking heading package
// Shared constants, types and codes of the zonal flocking heading unit.
// ----------------------------------------------------------------------------
package zfh_pkg;

  localparam int AGENTS      = 16;
  localparam int AGENT_W     = $clog2(AGENTS);
  localparam int IDX_W       = 4;
  localparam int BOX_LENGTH  = 100;
  localparam int ONE_Q16     = 65536;
  localparam int BOX_Q16     = BOX_LENGTH * ONE_Q16;
  localparam int HALF_BOX    = BOX_Q16 / 2;

  localparam int IN_POS_W    = 23;
  localparam int POS_W       = 24;
  localparam int VEL_W       = 18;
  localparam int RAD_W       = 23;
  localparam int HEAD_W      = 18;
  localparam int CNT_W       = 4;
  localparam int CNT_MAX     = 15;

  localparam int VEC_W       = 24;
  localparam int SQ_W        = 48;
  localparam int ROOT_W      = 24;
  localparam int REM_W       = 26;
  localparam int ROOT_STEPS  = 24;
  localparam int QUO_STEPS   = 17;
  localparam int STEP_W      = 5;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPULSE = 2'd0,
    REG_ORIENT  = 2'd1,
    REG_ATTRACT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } agent_row_t;

  typedef struct packed {
    logic              start;
    unit_op_e          op;
    logic [SQ_W-1:0]   arg;
    logic [ROOT_W-1:0] den;
    logic              neg;
  } unit_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [VEC_W-1:0] res;
  } unit_rsp_t;

endpackage

### design/zfh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zonal flocking heading channels
// Query, result and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface zfh_item_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [3:0]                 agent_index;
  logic signed [22:0]         pos_x;
  logic signed [22:0]         pos_y;
  logic signed [17:0]         vel_x;
  logic signed [17:0]         vel_y;

  modport source (output valid, command, agent_index, pos_x, pos_y, vel_x, vel_y,
                  input ready);
  modport sink   (input valid, command, agent_index, pos_x, pos_y, vel_x, vel_y,
                  output ready);
endinterface

interface zfh_result_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] heading_x;
  logic signed [17:0] heading_y;
  logic [3:0]         repulse_count;
  logic [3:0]         orient_count;
  logic [3:0]         attract_count;

  modport source (output valid, heading_x, heading_y, repulse_count, orient_count,
                  attract_count, input ready);
  modport sink   (input valid, heading_x, heading_y, repulse_count, orient_count,
                  attract_count, output ready);
endinterface

interface zfh_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [22:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/zfh_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Agent table
// One row per agent holding position and velocity, registered read port.
// ----------------------------------------------------------------------------
module zfh_table import zfh_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AGENT_W-1:0] wr_addr_i,
  input  agent_row_t         wr_row_i,
  input  logic [AGENT_W-1:0] rd_addr_i,
  output agent_row_t         rd_row_o
);

  agent_row_t mem [AGENTS];
  agent_row_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_row_o = rd_q;

endmodule

### design/zfh_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared root and divide unit
// One compare and subtract stage stepped once per cycle: an integer square
// root of two bits per step, or a unit-vector quotient of one bit per step.
// ----------------------------------------------------------------------------
module zfh_unit import zfh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic              busy_q, done_q, neg_q;
  unit_op_e          op_q;
  logic [STEP_W-1:0] cnt_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] acc_q;
  logic [SQ_W-1:0]   rad_q;
  logic [ROOT_W-1:0] den_q;

  logic [REM_W-1:0]  minuend, subtr, diff;
  logic              ge;

  always_comb begin
    if (op_q == OP_SQRT) begin
      minuend = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
      subtr   = {acc_q, 2'b01};
    end else begin
      minuend = rem_q;
      subtr   = REM_W'(den_q);
    end
    ge   = (minuend >= subtr);
    diff = ge ? (minuend - subtr) : minuend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      neg_q <= req_i.neg;
      den_q <= req_i.den;
      acc_q <= '0;
      rad_q <= req_i.arg;
      if (req_i.op == OP_SQRT) begin
        rem_q <= '0;
        cnt_q <= STEP_W'(ROOT_STEPS - 1);
      end else begin
        rem_q <= REM_W'(req_i.arg[ROOT_W-1:0]);
        cnt_q <= STEP_W'(QUO_STEPS - 1);
      end
    end else if (busy_q) begin
      acc_q <= {acc_q[ROOT_W-2:0], ge};
      rad_q <= {rad_q[SQ_W-3:0], 2'b00};
      rem_q <= (op_q == OP_SQRT) ? diff : {diff[REM_W-2:0], 1'b0};
      cnt_q <= cnt_q - STEP_W'(1);
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

### design/zonal_flocking_heading_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zonal flocking heading unit
// Stores agents and returns the zonal unit heading and zone counts of one.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// item_i    in         command, agent_index, pos_x, pos_y, vel_x, vel_y
// result_o  out        heading_x, heading_y, repulse/orient/attract counts
// cfg_i     in         register index and radius value
//
// A write item is stored in the cycle it is taken and the block is ready
// again at once. A heading item squares the three radii, skips its own row
// and reads each other agent to form its squared distance. For each agent
// in a zone, and for the final heading, it takes a root in the shared unit
// and then, unless the vector is zero, the two quotients. Reset clears
// control and sets the default radii; the table holds nothing until
// written. A stalled result waits in the output register.
// ----------------------------------------------------------------------------
module zonal_flocking_heading_unit import zfh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  zfh_item_if.sink     item_i,
  zfh_result_if.source result_o,
  zfh_cfg_if.sink      cfg_i
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RAD   = 15'b000000000000010,
    S_READ  = 15'b000000000000100,
    S_LOAD  = 15'b000000000001000,
    S_SQX   = 15'b000000000010000,
    S_SQY   = 15'b000000000100000,
    S_ZONE  = 15'b000000001000000,
    S_VX    = 15'b000000010000000,
    S_VY    = 15'b000000100000000,
    S_ROOT  = 15'b000001000000000,
    S_DIVX  = 15'b000010000000000,
    S_DIVY  = 15'b000100000000000,
    S_ACC   = 15'b001000000000000,
    S_FINAL = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  typedef enum logic [1:0] {
    Z_REP = 2'd0,
    Z_ORI = 2'd1,
    Z_ATT = 2'd2
  } zone_e;

  state_e state_q;
  zone_e  zone_q;

  logic [RAD_W-1:0]        rrad_q, orad_q, arad_q;
  logic [SQ_W-1:0]         rr2_q, ro2_q, ra2_q;
  logic [1:0]              k_q;
  logic [AGENT_W-1:0]      self_q, j_q;
  logic signed [POS_W-1:0] spx_q, spy_q;
  logic signed [VEL_W-1:0] svx_q, svy_q;
  logic signed [VEC_W-1:0] dx_q, dy_q, vx_q, vy_q, nvx_q, nvy_q;
  logic signed [VEC_W-1:0] rx_q, ry_q, ox_q, oy_q, ux_q, uy_q;
  logic [SQ_W-1:0]         sqa_q, s_q;
  logic [ROOT_W-1:0]       len_q;
  logic                    final_q, go_q;
  logic [CNT_W-1:0]        nrep_q, nori_q, natt_q;

  logic                    out_valid_q;
  logic signed [HEAD_W-1:0] out_hx_q, out_hy_q;
  logic [CNT_W-1:0]        out_rep_q, out_ori_q, out_att_q;

  logic                    in_acc, idx_ok, last_j;
  logic signed [VEC_W-1:0] mul_a, mul_b, absx, absy;
  logic signed [SQ_W-1:0]  prod;
  logic [RAD_W-1:0]        rad_sel;
  agent_row_t              wr_row, rd_row;
  unit_req_t               ureq;
  unit_rsp_t               ursp;

  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [IN_POS_W-1:0] v);
    logic signed [POS_W-1:0] w;
    w = POS_W'(v);
    if (w > $signed(POS_W'(HALF_BOX))) begin
      return POS_W'(HALF_BOX);
    end else if (w < -$signed(POS_W'(HALF_BOX))) begin
      return -$signed(POS_W'(HALF_BOX));
    end
    return w;
  endfunction

  function automatic logic signed [VEC_W-1:0] min_image(input logic signed [POS_W:0] d);
    logic signed [POS_W+2:0] dd, box;
    dd  = (POS_W+3)'(d);
    box = (POS_W+3)'(BOX_Q16);
    if ((dd <<< 1) >= box) begin
      return VEC_W'(dd - box);
    end else if ((dd <<< 1) <= -box) begin
      return VEC_W'(dd + box);
    end
    return VEC_W'(dd);
  endfunction

  assign item_i.ready = (state_q == S_IDLE);
  assign in_acc       = item_i.valid && item_i.ready;
  assign idx_ok       = int'(item_i.agent_index) < AGENTS;
  assign last_j       = (j_q == AGENT_W'(AGENTS - 1));
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rrad_q <= RAD_W'(ONE_Q16);
      orad_q <= RAD_W'(4 * ONE_Q16);
      arad_q <= RAD_W'(ONE_Q16);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_REPULSE: rrad_q <= cfg_i.data;
        REG_ORIENT:  orad_q <= cfg_i.data;
        REG_ATTRACT: arad_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign wr_row.pos_x = clamp_pos(item_i.pos_x);
  assign wr_row.pos_y = clamp_pos(item_i.pos_y);
  assign wr_row.vel_x = item_i.vel_x;
  assign wr_row.vel_y = item_i.vel_y;

  zfh_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && item_i.command == CMD_WRITE && idx_ok),
    .wr_addr_i (AGENT_W'(item_i.agent_index)),
    .wr_row_i  (wr_row),
    .rd_addr_i ((state_q == S_RAD) ? self_q : j_q),
    .rd_row_o  (rd_row)
  );

  always_comb begin
    case (k_q)
      2'd0:    rad_sel = rrad_q;
      2'd1:    rad_sel = orad_q;
      default: rad_sel = arad_q;
    endcase
    case (state_q)
      S_RAD: begin
        mul_a = VEC_W'(rad_sel);
        mul_b = VEC_W'(rad_sel);
      end
      S_SQX: begin
        mul_a = dx_q;
        mul_b = dx_q;
      end
      S_SQY: begin
        mul_a = dy_q;
        mul_b = dy_q;
      end
      S_VY: begin
        mul_a = vy_q;
        mul_b = vy_q;
      end
      default: begin
        mul_a = vx_q;
        mul_b = vx_q;
      end
    endcase
    prod = mul_a * mul_b;
  end

  assign absx = vx_q[VEC_W-1] ? -vx_q : vx_q;
  assign absy = vy_q[VEC_W-1] ? -vy_q : vy_q;

  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = OP_DIV;
    ureq.arg   = SQ_W'(absx);
    ureq.den   = len_q;
    ureq.neg   = vx_q[VEC_W-1];
    case (state_q)
      S_ROOT: begin
        ureq.start = !go_q;
        ureq.op    = OP_SQRT;
        ureq.arg   = s_q;
        ureq.neg   = 1'b0;
      end
      S_DIVX: ureq.start = !go_q;
      S_DIVY: begin
        ureq.start = !go_q;
        ureq.arg   = SQ_W'(absy);
        ureq.neg   = vy_q[VEC_W-1];
      end
      default: ;
    endcase
  end

  zfh_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .rsp_o  (ursp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      go_q        <= 1'b0;
      final_q     <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      nrep_q      <= '0;
      nori_q      <= '0;
      natt_q      <= '0;
    end else begin
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && item_i.command == CMD_QUERY && idx_ok) begin
            self_q  <= AGENT_W'(item_i.agent_index);
            k_q     <= '0;
            final_q <= 1'b0;
            nrep_q  <= '0;
            nori_q  <= '0;
            natt_q  <= '0;
            rx_q    <= '0;
            ry_q    <= '0;
            ox_q    <= '0;
            oy_q    <= '0;
            state_q <= S_RAD;
          end
        end
        S_RAD: begin
          case (k_q)
            2'd0:    rr2_q <= SQ_W'(prod);
            2'd1:    ro2_q <= SQ_W'(prod);
            default: ra2_q <= SQ_W'(prod);
          endcase
          k_q <= k_q + 2'd1;
          if (k_q == 2'd2) begin
            spx_q   <= rd_row.pos_x;
            spy_q   <= rd_row.pos_y;
            svx_q   <= rd_row.vel_x;
            svy_q   <= rd_row.vel_y;
            j_q     <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (j_q == self_q) begin
            if (last_j) begin
              state_q <= S_FINAL;
            end else begin
              j_q <= j_q + AGENT_W'(1);
            end
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          dx_q    <= min_image((POS_W+1)'(rd_row.pos_x) - (POS_W+1)'(spx_q));
          dy_q    <= min_image((POS_W+1)'(rd_row.pos_y) - (POS_W+1)'(spy_q));
          nvx_q   <= VEC_W'(rd_row.vel_x);
          nvy_q   <= VEC_W'(rd_row.vel_y);
          state_q <= S_SQX;
        end
        S_SQX: begin
          sqa_q   <= SQ_W'(prod);
          state_q <= S_SQY;
        end
        S_SQY: begin
          s_q     <= sqa_q + SQ_W'(prod);
          state_q <= S_ZONE;
        end
        S_ZONE: begin
          if (s_q < rr2_q) begin
            zone_q  <= Z_REP;
            vx_q    <= dx_q;
            vy_q    <= dy_q;
            nrep_q  <= (nrep_q == CNT_W'(CNT_MAX)) ? nrep_q : nrep_q + CNT_W'(1);
            state_q <= S_VX;
          end else if (s_q < ro2_q) begin
            zone_q  <= Z_ORI;
            vx_q    <= nvx_q;
            vy_q    <= nvy_q;
            nori_q  <= (nori_q == CNT_W'(CNT_MAX)) ? nori_q : nori_q + CNT_W'(1);
            state_q <= S_VX;
          end else if (s_q < ra2_q) begin
            zone_q  <= Z_ATT;
            vx_q    <= dx_q;
            vy_q    <= dy_q;
            natt_q  <= (natt_q == CNT_W'(CNT_MAX)) ? natt_q : natt_q + CNT_W'(1);
            state_q <= S_VX;
          end else if (last_j) begin
            state_q <= S_FINAL;
          end else begin
            j_q     <= j_q + AGENT_W'(1);
            state_q <= S_READ;
          end
        end
        S_VX: begin
          sqa_q   <= SQ_W'(prod);
          state_q <= S_VY;
        end
        S_VY: begin
          s_q     <= sqa_q + SQ_W'(prod);
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (!go_q) begin
            go_q <= 1'b1;
          end else if (ursp.done) begin
            go_q  <= 1'b0;
            len_q <= ursp.res;
            if (ursp.res == '0) begin
              ux_q    <= '0;
              uy_q    <= '0;
              state_q <= S_ACC;
            end else begin
              state_q <= S_DIVX;
            end
          end
        end
        S_DIVX: begin
          if (!go_q) begin
            go_q <= 1'b1;
          end else if (ursp.done) begin
            go_q    <= 1'b0;
            ux_q    <= ursp.res;
            state_q <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (!go_q) begin
            go_q <= 1'b1;
          end else if (ursp.done) begin
            go_q    <= 1'b0;
            uy_q    <= ursp.res;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (final_q) begin
            state_q <= S_OUT;
          end else begin
            if (zone_q == Z_REP) begin
              rx_q <= rx_q - ux_q;
              ry_q <= ry_q - uy_q;
            end else begin
              ox_q <= ox_q + ux_q;
              oy_q <= oy_q + uy_q;
            end
            if (last_j) begin
              state_q <= S_FINAL;
            end else begin
              j_q     <= j_q + AGENT_W'(1);
              state_q <= S_READ;
            end
          end
        end
        S_FINAL: begin
          if (nrep_q != '0) begin
            vx_q <= rx_q;
            vy_q <= ry_q;
          end else if (nori_q != '0 || natt_q != '0) begin
            vx_q <= ox_q;
            vy_q <= oy_q;
          end else begin
            vx_q <= VEC_W'(svx_q);
            vy_q <= VEC_W'(svy_q);
          end
          final_q <= 1'b1;
          state_q <= S_VX;
        end
        S_OUT: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            out_hx_q    <= ux_q[HEAD_W-1:0];
            out_hy_q    <= uy_q[HEAD_W-1:0];
            out_rep_q   <= nrep_q;
            out_ori_q   <= nori_q;
            out_att_q   <= natt_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.heading_x     = out_hx_q;
  assign result_o.heading_y     = out_hy_q;
  assign result_o.repulse_count = out_rep_q;
  assign result_o.orient_count  = out_ori_q;
  assign result_o.attract_count = out_att_q;

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && item_i.command == CMD_QUERY && idx_ok) |=> state_q == S_RAD)
    else $error("A heading item did not start the radius pass.");

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ursp.done |-> (state_q == S_ROOT || state_q == S_DIVX || state_q == S_DIVY))
    else $error("The shared unit finished outside a wait state.");

  a_out_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || result_o.ready)) |=> state_q == S_IDLE)
    else $error("A finished heading was not handed to the output register.");

  a_unit_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_hx_q <= $signed(HEAD_W'(ONE_Q16)) &&
                     out_hx_q >= -$signed(HEAD_W'(ONE_Q16))))
    else $error("Heading component exceeds one.");

endmodule
